>>> src/gspe_pkg.sv
// Shared types and constants for the graph shortest path engine.
// Used by graph_shortest_path_engine_top and gspe_edge_table; no dependencies.
package gspe_pkg;

   localparam int CNT_W           = 7;
   localparam int NODE_W          = 6;
   localparam int WEIGHT_W        = 16;
   localparam int DIST_W          = 22;
   localparam int NODE_FIELD_SLOTS = 64;

   localparam logic [CNT_W-1:0]  NODE_COUNT_RESET = 7'd64;
   localparam logic [DIST_W-1:0] DIST_SAT         = 22'h3F_FFFF;

   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   typedef struct packed {
      logic                func;
      logic [NODE_W-1:0]   from_node;
      logic [NODE_W-1:0]   to_node;
      logic [WEIGHT_W-1:0] weight;
   } req_type;

   typedef struct packed {
      logic signed [DIST_W:0] distance;
      logic [1:0]             status;
   } rsp_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0] weight;
      logic [NODE_W-1:0]   to_node;
      logic [NODE_W-1:0]   from_node;
   } edge_type;

endpackage

>>> src/graph_shortest_path_engine_top.sv
// Shortest path engine: an add loads its result from the done state once the output
// channel is free; a query runs rounds with one node scan and, if the table holds edges,
// one edge sweep per round, set by the single read port of the distance and edge memories.
// One transaction in flight: req_stall is high from acceptance until the result loads, so
// the next is taken in the cycle after at the earliest.
// Synchronous reset empties the edge table, sets node_count to 64. Needs gspe_pkg, gspe_edge_table.
module graph_shortest_path_engine_top #(
   parameter int MAX_NODES = 64,
   parameter int MAX_EDGES = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  gspe_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output gspe_pkg::rsp_type               rsp_data,
   input  logic                            csr_wr_en,
   input  logic [gspe_pkg::CNT_W-1:0]      csr_wr_data
);

   localparam int CW = gspe_pkg::CNT_W;
   localparam int DW = gspe_pkg::DIST_W;
   localparam int NODE_SLOTS = (MAX_NODES < gspe_pkg::NODE_FIELD_SLOTS) ?
                               MAX_NODES : gspe_pkg::NODE_FIELD_SLOTS;
   localparam int NW = $clog2(NODE_SLOTS);
   localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int TW = $clog2(MAX_EDGES + 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_INIT,
      S_ROUND,
      S_SCAN,
      S_FETCH,
      S_LOOKUP,
      S_UPDATE,
      S_FINAL_RD,
      S_FINAL,
      S_DONE
   } state_type;

   state_type          state_ff;
   logic [CW-1:0]      node_count_ff;
   logic [NW-1:0]      src_ff;
   logic [NW-1:0]      dst_ff;
   logic [CW-1:0]      scan_idx_ff;
   logic               pend_ff;
   logic [NW-1:0]      tag_ff;
   logic               found_ff;
   logic [NW-1:0]      best_ff;
   logic [DW-1:0]      best_dist_ff;
   logic [TW-1:0]      edge_idx_ff;
   logic [NODE_SLOTS-1:0] reached_ff;
   logic [NODE_SLOTS-1:0] settled_ff;
   gspe_pkg::rsp_type  res_ff;
   logic               rsp_valid_ff;
   gspe_pkg::rsp_type  rsp_data_ff;

   logic [DW-1:0]      dist_mem [NODE_SLOTS];
   logic [DW-1:0]      dist_rdata_ff;
   logic [NW-1:0]      dist_raddr;
   logic               dist_we;
   logic [NW-1:0]      dist_waddr;
   logic [DW-1:0]      dist_wdata;

   logic [CW-1:0]      cnt_eff;
   logic               req_bad;
   logic               accept;
   logic               edge_wr_en;
   gspe_pkg::edge_type edge_wr;
   gspe_pkg::edge_type edge_rd;
   logic [EW-1:0]      edge_raddr;
   logic [TW-1:0]      edge_total;
   logic               edge_full;
   logic [TW-1:0]      edge_next;

   logic               scan_issue;
   logic               scan_done;
   logic               cand;
   logic [NW-1:0]      t_idx;
   logic               t_ok;
   logic               f_match;
   logic [DW:0]        nd_sum;
   logic [DW-1:0]      nd;
   logic               relax_go;

   always_comb begin
      if (int'(node_count_ff) > MAX_NODES) begin
         cnt_eff = CW'(MAX_NODES);
      end else begin
         cnt_eff = node_count_ff;
      end
   end

   assign req_bad = ({1'b0, req_data.from_node} >= cnt_eff) ||
                    ({1'b0, req_data.to_node} >= cnt_eff);
   assign accept  = req_valid && (state_ff == S_IDLE);
   assign edge_wr_en = accept && (req_data.func == gspe_pkg::FUNC_ADD) &&
                       !req_bad && !edge_full;
   assign edge_wr.weight    = req_data.weight;
   assign edge_wr.to_node   = req_data.to_node;
   assign edge_wr.from_node = req_data.from_node;

   assign edge_next  = edge_idx_ff + TW'(1);
   assign edge_raddr = (state_ff == S_UPDATE) ? EW'(edge_next) : EW'(edge_idx_ff);

   gspe_edge_table #(
      .MAX_EDGES (MAX_EDGES)
   ) u_edge_table (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (edge_wr_en),
      .wr_edge    (edge_wr),
      .rd_addr    (edge_raddr),
      .rd_edge    (edge_rd),
      .edge_total (edge_total),
      .full       (edge_full)
   );

   assign scan_issue = (scan_idx_ff < cnt_eff);
   assign scan_done  = !scan_issue && !pend_ff;
   assign cand = pend_ff && reached_ff[tag_ff] && !settled_ff[tag_ff] &&
                 (!found_ff || (dist_rdata_ff < best_dist_ff));

   assign t_idx   = NW'(edge_rd.to_node);
   assign t_ok    = ({1'b0, edge_rd.to_node} < cnt_eff);
   assign f_match = ({1'b0, edge_rd.from_node} == CW'(best_ff));
   assign nd_sum  = {1'b0, best_dist_ff} + (DW + 1)'(edge_rd.weight);
   assign nd      = nd_sum[DW] ? gspe_pkg::DIST_SAT : nd_sum[DW-1:0];
   assign relax_go = (state_ff == S_UPDATE) && f_match && t_ok && !settled_ff[t_idx] &&
                     (!reached_ff[t_idx] || (nd < dist_rdata_ff));

   always_comb begin
      priority if (state_ff == S_SCAN) begin
         dist_raddr = NW'(scan_idx_ff);
      end else if (state_ff == S_LOOKUP) begin
         dist_raddr = t_idx;
      end else begin
         dist_raddr = dst_ff;
      end
   end

   assign dist_we    = (state_ff == S_INIT) || relax_go;
   assign dist_waddr = (state_ff == S_INIT) ? src_ff : t_idx;
   assign dist_wdata = (state_ff == S_INIT) ? '0 : nd;

   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[dist_waddr] <= dist_wdata;
      end
      dist_rdata_ff <= dist_mem[dist_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         node_count_ff <= gspe_pkg::NODE_COUNT_RESET;
         pend_ff       <= 1'b0;
         found_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            node_count_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req_data.func == gspe_pkg::FUNC_ADD) begin
                     res_ff.distance <= '0;
                     priority if (req_bad) begin
                        res_ff.status <= gspe_pkg::STATUS_INVALID;
                     end else if (edge_full) begin
                        res_ff.status <= gspe_pkg::STATUS_FULL;
                     end else begin
                        res_ff.status <= gspe_pkg::STATUS_OK;
                     end
                     state_ff <= S_DONE;
                  end else if (req_bad) begin
                     res_ff.distance <= '1;
                     res_ff.status   <= gspe_pkg::STATUS_INVALID;
                     state_ff        <= S_DONE;
                  end else begin
                     src_ff   <= NW'(req_data.from_node);
                     dst_ff   <= NW'(req_data.to_node);
                     state_ff <= S_INIT;
                  end
               end
            end
            S_INIT: begin
               reached_ff <= {{(NODE_SLOTS-1){1'b0}}, 1'b1} << src_ff;
               settled_ff <= '0;
               state_ff   <= S_ROUND;
            end
            S_ROUND: begin
               scan_idx_ff <= '0;
               pend_ff     <= 1'b0;
               found_ff    <= 1'b0;
               state_ff    <= S_SCAN;
            end
            S_SCAN: begin
               pend_ff <= scan_issue;
               tag_ff  <= NW'(scan_idx_ff);
               if (scan_issue) begin
                  scan_idx_ff <= scan_idx_ff + CW'(1);
               end
               if (cand) begin
                  found_ff     <= 1'b1;
                  best_ff      <= tag_ff;
                  best_dist_ff <= dist_rdata_ff;
               end
               if (scan_done) begin
                  if (found_ff) begin
                     settled_ff[best_ff] <= 1'b1;
                     edge_idx_ff         <= '0;
                     state_ff <= (edge_total == '0) ? S_ROUND : S_FETCH;
                  end else begin
                     state_ff <= S_FINAL_RD;
                  end
               end
            end
            S_FETCH: begin
               state_ff <= S_LOOKUP;
            end
            S_LOOKUP: begin
               state_ff <= S_UPDATE;
            end
            S_UPDATE: begin
               if (relax_go) begin
                  reached_ff[t_idx] <= 1'b1;
               end
               edge_idx_ff <= edge_next;
               state_ff    <= (edge_next == edge_total) ? S_ROUND : S_LOOKUP;
            end
            S_FINAL_RD: begin
               state_ff <= S_FINAL;
            end
            S_FINAL: begin
               res_ff.distance <= reached_ff[dst_ff] ? signed'({1'b0, dist_rdata_ff}) : '1;
               res_ff.status   <= gspe_pkg::STATUS_OK;
               state_ff        <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= res_ff;
                  state_ff     <= S_IDLE;
               end
            end
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_add_not_full: assert property (@(posedge clock) disable iff (reset)
      edge_wr_en |-> !edge_full)
      else $error("edge written into a full table");

   a_src_reached: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> reached_ff[src_ff])
      else $error("query source lost its reached flag");

   a_settle_best: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SCAN) && scan_done && found_ff) |=> settled_ff[$past(best_ff)])
      else $error("selected node not settled");

   a_relax_target: assert property (@(posedge clock) disable iff (reset)
      relax_go |-> (t_idx != best_ff))
      else $error("relaxation wrote the node being settled");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result loaded outside the done state");
`endif

endmodule

>>> src/gspe_edge_table.sv
// Directed edge table: append-only memory with a fill count and registered read.
// Depends on gspe_pkg for the edge record type.
module gspe_edge_table #(
   parameter int MAX_EDGES = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   wr_en,
   input  gspe_pkg::edge_type                     wr_edge,
   input  logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] rd_addr,
   output gspe_pkg::edge_type                     rd_edge,
   output logic [$clog2(MAX_EDGES + 1)-1:0]       edge_total,
   output logic                                   full
);

   localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int TW = $clog2(MAX_EDGES + 1);

   gspe_pkg::edge_type edge_mem [MAX_EDGES];
   gspe_pkg::edge_type rd_edge_ff;
   logic [TW-1:0]      total_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         edge_mem[EW'(total_ff)] <= wr_edge;
      end
      rd_edge_ff <= edge_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (wr_en) begin
         total_ff <= total_ff + TW'(1);
      end
   end

   assign full       = (total_ff == TW'(MAX_EDGES));
   assign edge_total = total_ff;
   assign rd_edge    = rd_edge_ff;

endmodule

>>> tb/graph_shortest_path_engine_top_tb.sv
// Self-checking testbench for graph_shortest_path_engine_top: edge adds and route queries
// over valid/stall channels, results checked against an in-bench Dijkstra predictor.
// Depends on gspe_pkg and the engine RTL.
module graph_shortest_path_engine_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODE_SLOTS = 64;
   localparam int EDGE_SLOTS = 256;
   localparam int CW         = gspe_pkg::CNT_W;
   localparam int NWD        = gspe_pkg::NODE_W;
   localparam int WW         = gspe_pkg::WEIGHT_W;
   localparam int DW         = gspe_pkg::DIST_W;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   gspe_pkg::req_type req_data    = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   gspe_pkg::rsp_type rsp_data;
   logic              csr_wr_en   = 1'b0;
   logic [CW-1:0]     csr_wr_data = '0;

   gspe_pkg::req_type request_backlog[$];
   gspe_pkg::rsp_type expected_answers[$];

   int unsigned       node_limit = gspe_pkg::NODE_COUNT_RESET;
   logic [NWD-1:0]    edge_src  [EDGE_SLOTS];
   logic [NWD-1:0]    edge_dst  [EDGE_SLOTS];
   logic [WW-1:0]     edge_cost [EDGE_SLOTS];
   int unsigned       edge_count = 0;

   int    error_count     = 0;
   int    sender_wait     = 0;
   int    receiver_wait   = 0;
   bit    sender_gaps     = 1'b1;
   bit    receiver_stalls = 1'b1;
   longint cycle_count    = 0;
   longint cycle_budget   = 0;

   graph_shortest_path_engine_top #(
      .MAX_NODES(NODE_SLOTS),
      .MAX_EDGES(EDGE_SLOTS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int unsigned active_count();
      return (node_limit > NODE_SLOTS) ? NODE_SLOTS : node_limit;
   endfunction

   function automatic logic signed [DW:0] cheapest_route(input int unsigned src,
                                                         input int unsigned dst,
                                                         input int unsigned cnt);
      int unsigned node_cost [NODE_SLOTS];
      bit          settled   [NODE_SLOTS];
      bit          reached   [NODE_SLOTS];
      int unsigned best;
      int unsigned nd;
      int unsigned t;
      bit          found;
      int          i;
      int          r;
      int          e;
      for (i = 0; i < NODE_SLOTS; i++) begin
         node_cost[i] = 0;
         settled[i]   = 1'b0;
         reached[i]   = 1'b0;
      end
      reached[src] = 1'b1;
      for (r = 0; r < cnt; r++) begin
         found = 1'b0;
         best  = 0;
         for (i = 0; i < cnt; i++) begin
            if (reached[i] && !settled[i] && (!found || node_cost[i] < node_cost[best])) begin
               best  = i;
               found = 1'b1;
            end
         end
         if (!found)
            break;
         settled[best] = 1'b1;
         for (e = 0; e < edge_count; e++) begin
            t = edge_dst[e];
            if (edge_src[e] == best && t < cnt && !settled[t]) begin
               nd = node_cost[best] + edge_cost[e];
               if (nd > gspe_pkg::DIST_SAT)
                  nd = gspe_pkg::DIST_SAT;
               if (!reached[t] || nd < node_cost[t]) begin
                  node_cost[t] = nd;
                  reached[t]   = 1'b1;
               end
            end
         end
      end
      if (!reached[dst])
         return '1;
      return (DW + 1)'(node_cost[dst]);
   endfunction

   function automatic gspe_pkg::rsp_type path_outcome(input gspe_pkg::req_type item);
      gspe_pkg::rsp_type res;
      int unsigned       cnt;
      bit                bad;
      cnt = active_count();
      bad = (item.from_node >= cnt) || (item.to_node >= cnt);
      res.distance = '0;
      res.status   = gspe_pkg::STATUS_OK;
      if (item.func == gspe_pkg::FUNC_ADD) begin
         if (bad) begin
            res.status = gspe_pkg::STATUS_INVALID;
         end else if (edge_count >= EDGE_SLOTS) begin
            res.status = gspe_pkg::STATUS_FULL;
         end else begin
            edge_src[edge_count]  = item.from_node;
            edge_dst[edge_count]  = item.to_node;
            edge_cost[edge_count] = item.weight;
            edge_count++;
         end
      end else if (bad) begin
         res.distance = '1;
         res.status   = gspe_pkg::STATUS_INVALID;
      end else begin
         res.distance = cheapest_route(item.from_node, item.to_node, cnt);
      end
      return res;
   endfunction

   function automatic int unsigned draw_weight();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 16'hFFFF;
         2: return $urandom_range(1, 16);
         default: return $urandom_range(0, 16'hFFFF);
      endcase
   endfunction

   task automatic enqueue_request(input logic func, input int unsigned src,
                                  input int unsigned dst, input int unsigned weight);
      gspe_pkg::req_type item;
      int unsigned       n;
      item.func      = func;
      item.from_node = NWD'(src);
      item.to_node   = NWD'(dst);
      item.weight    = WW'(weight);
      request_backlog = {request_backlog, item};
      n = active_count();
      if (func == gspe_pkg::FUNC_QUERY)
         cycle_budget += n * (n + 2 * EDGE_SLOTS + 4) + n + 7 + 30;
      else
         cycle_budget += 1 + 30;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (request_backlog.size() != 0 || req_valid || expected_answers.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_node_count(input int unsigned value);
      logic [CW-1:0] v;
      v = CW'(value);
      wait_idle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      node_limit      = v;
      sender_gaps     = ($urandom_range(0, 3) != 0);
      receiver_stalls = ($urandom_range(0, 3) != 0);
      @(negedge clock);
   endtask

   // Driver: present the next pending transaction, hold it while stalled.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         sender_wait = 0;
      end else begin
         if (req_valid && !req_stall)
            expected_answers = {expected_answers, path_outcome(req_data)};
         if (!req_valid || !req_stall) begin
            if (sender_wait > 0) begin
               sender_wait--;
               req_valid <= 1'b0;
            end else if (request_backlog.size() > 0) begin
               req_data  <= request_backlog.pop_front();
               req_valid <= 1'b1;
               sender_wait = sender_gaps ? $urandom_range(0, 9) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      gspe_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         receiver_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_answers.size() == 0) begin
               $error("unexpected rsp transaction: distance %0d status %0d",
                      rsp_data.distance, rsp_data.status);
               error_count++;
            end else begin
               want = expected_answers.pop_front();
               if (rsp_data.distance !== want.distance) begin
                  $error("distance: expected %0d, actual %0d", want.distance, rsp_data.distance);
                  error_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
                  error_count++;
               end
            end
            receiver_wait = receiver_stalls ? $urandom_range(0, 9) : 0;
         end
         if (receiver_wait > 0) begin
            rsp_stall <= 1'b1;
            receiver_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 4 * cycle_budget + 10000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int k;
      int phase;
      int pick;
      int unsigned cnt;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table, then a max-weight chain across every node
      enqueue_request(gspe_pkg::FUNC_QUERY, 0, 0, 0);
      enqueue_request(gspe_pkg::FUNC_QUERY, 0, 63, 16'hFFFF);
      enqueue_request(gspe_pkg::FUNC_QUERY, 63, 63, 0);
      for (k = 0; k < 63; k++)
         enqueue_request(gspe_pkg::FUNC_ADD, k, k + 1, 16'hFFFF);
      enqueue_request(gspe_pkg::FUNC_QUERY, 0, 63, 0);
      enqueue_request(gspe_pkg::FUNC_QUERY, 63, 0, 0);
      enqueue_request(gspe_pkg::FUNC_QUERY, 20, 41, 0);
      enqueue_request(gspe_pkg::FUNC_ADD, 63, 0, 0);
      enqueue_request(gspe_pkg::FUNC_ADD, 0, 0, 16'h5555);
      enqueue_request(gspe_pkg::FUNC_ADD, 10, 50, 16'hAAAA);
      enqueue_request(gspe_pkg::FUNC_ADD, 10, 50, 3);
      enqueue_request(gspe_pkg::FUNC_QUERY, 63, 62, 0);
      enqueue_request(gspe_pkg::FUNC_QUERY, 0, 50, 0);

      set_node_count(1);
      enqueue_request(gspe_pkg::FUNC_ADD, 0, 1, 7);
      enqueue_request(gspe_pkg::FUNC_QUERY, 0, 0, 0);
      enqueue_request(gspe_pkg::FUNC_QUERY, 63, 0, 0);

      set_node_count(0);
      enqueue_request(gspe_pkg::FUNC_ADD, 0, 0, 0);
      enqueue_request(gspe_pkg::FUNC_QUERY, 0, 0, 0);

      set_node_count(127);
      enqueue_request(gspe_pkg::FUNC_QUERY, 0, 63, 0);

      set_node_count(11);
      enqueue_request(gspe_pkg::FUNC_QUERY, 0, 10, 0);
      enqueue_request(gspe_pkg::FUNC_QUERY, 10, 50, 0);

      for (phase = 0; phase < 2; phase++) begin
         set_node_count((phase == 1) ? 64 : $urandom_range(2, 12));
         cnt = active_count();
         for (k = 0; k < 9; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
               enqueue_request(gspe_pkg::FUNC_ADD, $urandom_range(0, cnt - 1),
                               $urandom_range(0, cnt - 1), draw_weight());
            else if (pick < 85)
               enqueue_request(gspe_pkg::FUNC_QUERY, $urandom_range(0, cnt - 1),
                               $urandom_range(0, cnt - 1), $urandom);
            else
               enqueue_request(1'($urandom_range(0, 1)), $urandom_range(0, 63),
                               $urandom_range(0, 63), $urandom);
         end
      end

      set_node_count(64);
      enqueue_request(gspe_pkg::FUNC_QUERY, 0, 63, 0);

      wait_idle();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
